>>> rtl/pcs_pkg.sv
package pcs_pkg;

	// Field and register widths.
	localparam int IN_W       = 16;
	localparam int ERR_W      = IN_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int INTEG_W    = 32;
	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 32;
	localparam int WIN_W      = 17;
	localparam int IDX_W      = 3;
	localparam int CFG_DATA_W = 32;

	// Product, accumulator and scaled widths of the back end.
	localparam int FRAC_W     = 8;
	localparam int P_PROD_W   = GAIN_W + ERR_W;
	localparam int I_PROD_W   = GAIN_W + INTEG_W;
	localparam int D_PROD_W   = GAIN_W + DIFF_W;
	localparam int ACC_W      = I_PROD_W + 2;
	localparam int SCL_W      = ACC_W - FRAC_W;

	// Queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register reset values.
	localparam logic signed [GAIN_W-1:0]  PROP_GAIN_RST    = GAIN_W'(256);
	localparam logic signed [GAIN_W-1:0]  INTEG_GAIN_RST   = '0;
	localparam logic signed [GAIN_W-1:0]  DERIV_GAIN_RST   = '0;
	localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST  = {1'b0, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST  = {1'b1, {(DRIVE_W-1){1'b0}}};
	localparam logic [WIN_W-1:0]          INTEG_WINDOW_RST = WIN_W'(65536);

	// Saturation limits of the integral.
	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_DRIVE_UPPER  = 3'd3,
		REG_DRIVE_LOWER  = 3'd4,
		REG_INTEG_WINDOW = 3'd5
	} cfg_reg_t;

	// One prepared sample, as handed from the front end to the back end.
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DIFF_W-1:0]  diff;
	} pcs_item_t;

	// Settings used by the back end.
	typedef struct packed {
		logic signed [GAIN_W-1:0]  prop_gain;
		logic signed [GAIN_W-1:0]  integ_gain;
		logic signed [GAIN_W-1:0]  deriv_gain;
		logic signed [DRIVE_W-1:0] drive_upper;
		logic signed [DRIVE_W-1:0] drive_lower;
	} pcs_back_cfg_t;

endpackage

>>> rtl/pcs_front.sv
module pcs_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pcs_pkg::WIN_W-1:0]            integ_window,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pcs_pkg::IN_W-1:0]      target,
	input  logic signed [pcs_pkg::IN_W-1:0]      measured,
	output logic                                 push,
	input  logic                                 push_ready,
	output pcs_pkg::pcs_item_t                   item
);
	import pcs_pkg::*;

	logic signed [INTEG_W-1:0] integ_sum_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [ERR_W-1:0]   err;
	logic [ERR_W-1:0]          mag;
	logic signed [INTEG_W:0]   sum_ext;
	logic signed [INTEG_W-1:0] integ_next;

	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	always_comb begin
		err = ERR_W'(target) - ERR_W'(measured);
		mag = err[ERR_W-1] ? ERR_W'(-err) : err;
		sum_ext = (INTEG_W+1)'(integ_sum_q) + (INTEG_W+1)'(err);
		if (mag >= integ_window) begin
			// Error outside the window: the integral is discarded.
			integ_next = '0;
		end else if (sum_ext[INTEG_W] != sum_ext[INTEG_W-1]) begin
			integ_next = sum_ext[INTEG_W] ? INTEG_MIN : INTEG_MAX;
		end else begin
			integ_next = sum_ext[INTEG_W-1:0];
		end
		item.err   = err;
		item.integ = integ_next;
		item.diff  = DIFF_W'(prev_err_q) - DIFF_W'(err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (push) begin
			integ_sum_q <= integ_next;
			prev_err_q  <= err;
		end
	end

endmodule

>>> rtl/pcs_queue.sv
module pcs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               push_ready,
	input  pcs_pkg::pcs_item_t push_item,
	output logic               pop_valid,
	input  logic               pop,
	output pcs_pkg::pcs_item_t pop_item
);
	import pcs_pkg::*;

	pcs_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

endmodule

>>> rtl/pcs_back.sv
module pcs_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcs_pkg::pcs_back_cfg_t               cfg,
	input  logic                                 q_valid,
	output logic                                 q_pop,
	input  pcs_pkg::pcs_item_t                   item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pcs_pkg::DRIVE_W-1:0]   drive
);
	import pcs_pkg::*;

	logic                       valid_s1;
	logic signed [P_PROD_W-1:0] p_prod_s1;
	logic signed [I_PROD_W-1:0] i_prod_s1;
	logic signed [D_PROD_W-1:0] d_prod_s1;
	logic                       out_valid_q;
	logic signed [DRIVE_W-1:0]  drive_q;
	logic                       adv1;
	logic                       adv2;
	logic signed [ACC_W-1:0]    acc;
	logic signed [SCL_W-1:0]    scaled;
	logic signed [DRIVE_W-1:0]  drive_next;

	assign adv2      = !out_valid_q || out_ready;
	assign adv1      = !valid_s1 || adv2;
	assign q_pop     = q_valid && adv1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Stage 1: the three products.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			p_prod_s1 <= P_PROD_W'(cfg.prop_gain) * P_PROD_W'(item.err);
			i_prod_s1 <= I_PROD_W'(cfg.integ_gain) * I_PROD_W'(item.integ);
			d_prod_s1 <= D_PROD_W'(cfg.deriv_gain) * D_PROD_W'(item.diff);
		end
	end

	// Stage 2: sum, drop the fraction (floor) and clamp, upper bound first.
	always_comb begin
		acc    = ACC_W'(p_prod_s1) + ACC_W'(i_prod_s1) + ACC_W'(d_prod_s1);
		scaled = SCL_W'(acc >>> FRAC_W);
		if (scaled > SCL_W'(cfg.drive_upper)) begin
			drive_next = cfg.drive_upper;
		end else if (scaled < SCL_W'(cfg.drive_lower)) begin
			drive_next = cfg.drive_lower;
		end else begin
			drive_next = scaled[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv2) begin
			drive_q <= drive_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= q_valid;
			end
			if (adv2) begin
				out_valid_q <= valid_s1;
			end
		end
	end

endmodule

>>> rtl/pid_controller_step_core.sv
// Discrete PID controller with integral reset, one sample per request.
//
// Input channel (in_valid/in_ready) carries a request of target and measured.
// Output channel (out_valid/out_ready) returns one drive value per request, in
// request order. Settings are written through cfg_we/cfg_idx/cfg_data; a write
// takes effect at the clock edge where cfg_we is high, and writes to unused
// indexes are ignored. Settings should only change while no request is in flight.
//
// The front end works out the error, the windowed and saturated integral and the
// derivative difference, and updates its state in the cycle a request is taken.
// A two-entry queue sits between it and the back end, which forms the three
// products in one stage and the sum, floor shift and clamp in a second stage.
// out_valid rises once the request has passed the queue entry, the stage-1 product
// registers and the output register; one request per cycle is sustained while
// out_ready stays high, as the front end updates its state as each request is taken.
// When the receiver stalls, the back end holds and the queue fills; in_ready falls
// once the two queue entries are occupied, so nothing is lost.
// Reset clears the integral and previous error, empties the pipeline and loads
// the default settings (unity proportional gain, open clamp limits, full window).
module pid_controller_step_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pcs_pkg::IN_W-1:0]       target,
	input  logic signed [pcs_pkg::IN_W-1:0]       measured,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pcs_pkg::DRIVE_W-1:0]    drive,
	input  logic                                  cfg_we,
	input  logic [pcs_pkg::IDX_W-1:0]             cfg_idx,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pcs_pkg::*;

	pcs_back_cfg_t    back_cfg_q;
	logic [WIN_W-1:0] integ_window_q;

	logic             q_push;
	logic             q_ready;
	logic             q_valid;
	logic             q_pop;
	pcs_item_t        push_item;
	pcs_item_t        pop_item;

	// Settings registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_cfg_q.prop_gain   <= PROP_GAIN_RST;
			back_cfg_q.integ_gain  <= INTEG_GAIN_RST;
			back_cfg_q.deriv_gain  <= DERIV_GAIN_RST;
			back_cfg_q.drive_upper <= DRIVE_UPPER_RST;
			back_cfg_q.drive_lower <= DRIVE_LOWER_RST;
			integ_window_q         <= INTEG_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_PROP_GAIN:    back_cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:   back_cfg_q.integ_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:   back_cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_UPPER:  back_cfg_q.drive_upper <= cfg_data[DRIVE_W-1:0];
				REG_DRIVE_LOWER:  back_cfg_q.drive_lower <= cfg_data[DRIVE_W-1:0];
				REG_INTEG_WINDOW: integ_window_q         <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pcs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.integ_window (integ_window_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target       (target),
		.measured     (measured),
		.push         (q_push),
		.push_ready   (q_ready),
		.item         (push_item)
	);

	pcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (pop_item)
	);

	pcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.item      (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	// An accepted request is waiting in the queue in the following cycle.
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> q_valid)
		else $error("accepted request did not reach the queue");

	// A full queue, which blocks the input, must hold something for the back end.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_ready |-> q_valid)
		else $error("queue reports full and empty at once");

	// With a zero window every sample discards the integral.
	a_zero_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && (integ_window_q == '0) |-> (push_item.integ == '0))
		else $error("integral kept although the window is zero");

endmodule

>>> sim/pid_step_checker.sv
`timescale 1ns / 100ps

module pid_step_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [pcs_pkg::IN_W-1:0]    target,
	input  logic signed [pcs_pkg::IN_W-1:0]    measured,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [pcs_pkg::DRIVE_W-1:0] drive,
	input  logic                               cfg_we,
	input  logic [pcs_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int unsigned                        fail_count,
	output int unsigned                        pending_count
);

	// Local copy of the settings and of the loop state.
	longint prop_k, integ_k, deriv_k, upper_lim, lower_lim, window_lim;
	longint integ_acc, last_err;

	logic signed [pcs_pkg::DRIVE_W-1:0] drive_due[$];
	int unsigned mismatches;

	// Advances the loop state by one sample and returns the clamped drive.
	function automatic logic signed [31:0] next_drive(input longint tgt, input longint meas);
		longint err, mag, diff, sum, scaled;
		err = tgt - meas;
		mag = (err < 0) ? -err : err;
		if (mag < window_lim) begin
			sum = integ_acc + err;
			if (sum > 64'sd2147483647)
				sum = 64'sd2147483647;
			if (sum < -64'sd2147483648)
				sum = -64'sd2147483648;
			integ_acc = sum;
		end else begin
			integ_acc = 0;
		end
		diff = last_err - err;
		last_err = err;
		sum = prop_k * err + integ_k * integ_acc + deriv_k * diff;
		// Arithmetic shift of a signed value rounds towards minus infinity.
		scaled = sum >>> 8;
		if (scaled > upper_lim)
			scaled = upper_lim;
		else if (scaled < lower_lim)
			scaled = lower_lim;
		return scaled[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [pcs_pkg::DRIVE_W-1:0] want;
		if (!arst_n) begin
			prop_k = 256;
			integ_k = 0;
			deriv_k = 0;
			upper_lim = 64'sd2147483647;
			lower_lim = -64'sd2147483648;
			window_lim = 65536;
			integ_acc = 0;
			last_err = 0;
			drive_due.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					pcs_pkg::REG_PROP_GAIN:    prop_k = longint'($signed(cfg_data[15:0]));
					pcs_pkg::REG_INTEG_GAIN:   integ_k = longint'($signed(cfg_data[15:0]));
					pcs_pkg::REG_DERIV_GAIN:   deriv_k = longint'($signed(cfg_data[15:0]));
					pcs_pkg::REG_DRIVE_UPPER:  upper_lim = longint'($signed(cfg_data));
					pcs_pkg::REG_DRIVE_LOWER:  lower_lim = longint'($signed(cfg_data));
					pcs_pkg::REG_INTEG_WINDOW: window_lim = longint'(cfg_data[16:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				drive_due.push_back(next_drive(longint'(target), longint'(measured)));
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					mismatches++;
					$display("%0t: drive %0d returned with no request outstanding",
						$time, drive);
				end else begin
					want = drive_due.pop_front();
					if (drive !== want) begin
						mismatches++;
						$display("%0t: drive mismatch, expected %0d, got %0d",
							$time, want, drive);
					end
				end
			end
			fail_count <= mismatches;
			pending_count <= drive_due.size();
		end
	end

endmodule

>>> sim/tb_pid_controller_step_core.sv
`timescale 1ns / 100ps

module tb_pid_controller_step_core;

	import pcs_pkg::*;

	// Timeout, generous against the slowest legal run of fewer than 500 requests,
	// with the receiver at its lowest ready rate and the sender at its longest gaps.
	localparam int CYCLE_LIMIT     = 200000;
	// Idle wait after the last drive returns, before any further register write.
	localparam int DRAIN_CYCLES    = 8;
	localparam int SAT_ITEMS       = 80;
	localparam int RANDOM_PHASES   = 5;
	localparam int ITEMS_PER_PHASE = 60;

	// Indexes that decode to no register; writes to them must be ignored.
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [31:0] DRIVE_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] DRIVE_MIN = 32'h8000_0000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [IN_W-1:0]      target = '0;
	logic signed [IN_W-1:0]      measured = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [DRIVE_W-1:0]   drive;
	logic                        cfg_we = 1'b0;
	logic [IDX_W-1:0]            cfg_idx = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	int unsigned fail_count;
	int unsigned pending_count;
	int          cycle_count = 0;

	// Sender pacing: requests go out in bursts with idle gaps between them,
	// unless gaps are switched off for a phase.
	bit gaps_on = 1'b1;
	int burst_left = 4;

	// Receiver pacing: the ready rate changes every so often, from always
	// ready through to a hard stall.
	int ready_pct = 100;
	int ready_span = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pid_controller_step_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.target    (target),
		.measured  (measured),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	pid_step_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target        (target),
		.measured      (measured),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver stall pattern. Each span picks a ready rate; the last choice is
	// a short hard stall, which lets the internal queue fill and back up the
	// input side.
	always @(posedge clk) begin
		if (ready_span <= 0) begin
			ready_span = $urandom_range(8, 80);
			case ($urandom_range(0, 4))
				0: ready_pct = 100;
				1: ready_pct = 85;
				2: ready_pct = 50;
				3: ready_pct = 20;
				default: begin
					ready_pct = 0;
					ready_span = $urandom_range(2, 30);
				end
			endcase
		end
		ready_span--;
		out_ready <= (int'($urandom_range(0, 99)) < ready_pct);
	end

	// Presents one request and holds it until the block takes it. After the
	// last request of a burst the valid line is dropped for a random gap; the
	// gap always advances time, so valid never sees two assignments in one step.
	task automatic send_request(input int t, input int m);
		in_valid <= 1'b1;
		target <= IN_W'(t);
		measured <= IN_W'(m);
		do @(posedge clk); while (!in_ready);
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end
		end
	endtask

	// Stops sending and waits until every request has produced its drive,
	// then lets the pipeline run empty for a few more cycles.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller lowers the write enable after a series.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Writes all six registers. The unused upper bits of the narrow registers
	// carry random junk, which the block must discard.
	task automatic load_settings(input int pg, input int ig, input int dg,
			input logic [31:0] upper, input logic [31:0] lower, input int win);
		write_reg(REG_PROP_GAIN, {16'($urandom), 16'(pg)});
		write_reg(REG_INTEG_GAIN, {16'($urandom), 16'(ig)});
		write_reg(REG_DERIV_GAIN, {16'($urandom), 16'(dg)});
		write_reg(REG_DRIVE_UPPER, upper);
		write_reg(REG_DRIVE_LOWER, lower);
		write_reg(REG_INTEG_WINDOW, {15'($urandom), 17'(win)});
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_gain();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(0, 1023)) - 512;
			3: return int'($urandom_range(0, 65535)) - 32768;
			default: return 0;
		endcase
	endfunction

	function automatic int pick_sample();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	task automatic randomise_settings();
		logic [31:0] upper, lower;
		int win;
		case ($urandom_range(0, 3))
			0: begin
				upper = DRIVE_MAX;
				lower = DRIVE_MIN;
			end
			1: begin
				upper = $urandom_range(0, 5000);
				lower = -int'($urandom_range(0, 5000));
			end
			// Upper limit below the lower one: the upper check must still win.
			2: begin
				upper = -int'($urandom_range(1, 1000));
				lower = $urandom_range(1, 1000);
			end
			default: begin
				upper = $urandom;
				lower = $urandom;
			end
		endcase
		case ($urandom_range(0, 4))
			0: win = 0;
			1: win = 131071;
			2: win = 65536;
			3: win = $urandom_range(1, 300);
			default: win = $urandom_range(0, 131071);
		endcase
		load_settings(pick_gain(), pick_gain(), pick_gain(), upper, lower, win);
	endtask

	// A random request: mostly full-range or small errors (so the integral has
	// a chance to build up inside the window), sometimes extreme samples.
	task automatic send_random_request();
		int pick, t, m;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			t = int'($urandom_range(0, 65535)) - 32768;
			m = int'($urandom_range(0, 65535)) - 32768;
		end else if (pick < 8) begin
			t = int'($urandom_range(0, 65535)) - 32768;
			m = t - (int'($urandom_range(0, 400)) - 200);
			if (m > 32767)
				m = 32767;
			if (m < -32768)
				m = -32768;
		end else begin
			t = pick_sample();
			m = pick_sample();
		end
		send_request(t, m);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: unity proportional gain, open clamps, full window.
		// The largest errors of either sign come first.
		send_request(32767, -32768);
		send_request(-32768, 32767);
		send_request(0, 0);
		send_request(-1, 0);
		send_request(5, 5);
		settle();

		// Extreme gains of both signs against a narrow clamp.
		load_settings(32767, -32768, 32767, 32'd1000, -32'sd1000, 131071);
		send_request(32767, -32768);
		send_request(-32768, 32767);
		send_request(3, -4);
		send_request(-7, 2);
		send_request(0, 0);
		settle();

		// Upper limit below the lower limit, with the other gain extremes.
		load_settings(-32768, 32767, -32768, -32'sd5, 32'd5, 70000);
		send_request(100, 0);
		send_request(-100, 0);
		send_request(0, 0);
		settle();

		// A zero window clears the integral on every request. Gains that are not
		// multiples of one make the floor rounding of negative sums visible.
		load_settings(77, 300, -129, DRIVE_MAX, DRIVE_MIN, 0);
		send_request(-3, 0);
		send_request(1, -1);
		send_request(12345, -12345);
		settle();

		// Writes to the unused indexes must leave every setting alone.
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0000);
		cfg_we <= 1'b0;
		send_request(-5, 3);
		send_request(32767, 32767);
		settle();

		// Window edge: an error equal to the window clears, one below it adds.
		load_settings(256, 256, 256, DRIVE_MAX, DRIVE_MIN, 100);
		send_request(50, -50);
		send_request(49, -50);
		send_request(-50, 50);
		settle();

		// Build the integral up with the largest positive errors, with the
		// sender running flat out.
		gaps_on = 1'b0;
		load_settings($urandom_range(0, 600), $urandom_range(1, 255),
			int'($urandom_range(0, 600)) - 300, DRIVE_MAX, DRIVE_MIN, 65536);
		repeat (SAT_ITEMS)
			send_request(32767 - int'($urandom_range(0, 7)), -32768 + int'($urandom_range(0, 7)));
		settle();

		// Clear it with a zero window, then build it down with the largest
		// negative errors.
		load_settings(256, 1, 0, DRIVE_MAX, DRIVE_MIN, 0);
		send_request(1, 0);
		settle();
		load_settings(-int'($urandom_range(0, 600)), -int'($urandom_range(1, 255)),
			int'($urandom_range(0, 600)) - 300, DRIVE_MAX, DRIVE_MIN, 131071);
		repeat (SAT_ITEMS)
			send_request(-32768 + int'($urandom_range(0, 7)), 32767 - int'($urandom_range(0, 7)));
		settle();
		gaps_on = 1'b1;

		// Random phases, each under fresh settings. One phase runs without
		// sender gaps so the block sees back-to-back requests under stalls.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			randomise_settings();
			gaps_on = (phase != 2);
			repeat (ITEMS_PER_PHASE)
				send_random_request();
			settle();
		end

		if (fail_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/pcs_pkg.sv
rtl/pcs_front.sv
rtl/pcs_queue.sv
rtl/pcs_back.sv
rtl/pid_controller_step_core.sv
sim/pid_step_checker.sv
sim/tb_pid_controller_step_core.sv
